/* hw/rtl/scg_pkg.sv */
package scg_pkg;

    // Window table size and its index width.
    localparam int MAX_WINDOWS = 8;
    localparam int WIN_IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    // Gaussian table, a power of two in size.
    localparam int GAUSS_LOG2    = 8;
    localparam int GAUSS_ENTRIES = 1 << GAUSS_LOG2;

    // Shared divider: one quotient bit per step.
    localparam int DIVP_STEPS = 32;
    localparam int DIVG_STEPS = 32 + GAUSS_LOG2;
    localparam int DVD_W      = 32 + GAUSS_LOG2;

    localparam int CNT_MAX = (DIVG_STEPS > MAX_WINDOWS) ? DIVG_STEPS : MAX_WINDOWS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration port.
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_START    = 3'd1;
    localparam logic [2:0] REG_DURATION = 3'd2;
    localparam logic [2:0] REG_PERIOD   = 3'd3;
    localparam logic [2:0] REG_AMP      = 3'd4;
    localparam logic [2:0] REG_AREA_LO  = 3'd5;
    localparam logic [2:0] REG_AREA_HI  = 3'd6;
    localparam logic [2:0] REG_WCOUNT   = 3'd7;

    // Bit positions inside the mode register.
    localparam int MODE_MANUAL  = 0;
    localparam int MODE_SPATIAL = 1;
    localparam int MODE_RECT    = 2;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        pulse_start;
        logic [31:0]        pulse_duration;
        logic [31:0]        pulse_period;
        logic signed [31:0] pulse_amplitude;
        logic [63:0]        area_low;
        logic [63:0]        area_high;
        logic [3:0]         window_count;
    } t_cfg;

    typedef struct packed {
        logic               func;
        logic [31:0]        time_req;
        logic [15:0]        node_index;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic [2:0]         window_slot;
        logic [31:0]        window_end;
        logic signed [31:0] window_amplitude;
    } t_req;

    typedef enum logic [2:0] {
        MUL_SQX,
        MUL_SQY,
        MUL_SQR,
        MUL_NP,
        MUL_AMP
    } t_mul_sel;

    typedef struct packed {
        logic                 win_write;
        logic                 load_item;
        t_mul_sel             mul_sel;
        logic                 save_sa;
        logic                 save_sb;
        logic                 area_eval;
        logic                 div_load_p;
        logic                 div_load_g;
        logic                 div_step;
        logic                 base_calc;
        logic                 scan_step;
        logic [WIN_IDX_W-1:0] scan_idx;
        logic                 gauss_res;
        logic                 out_load;
    } t_cmd;

    typedef struct packed {
        logic need_gauss;
        logic dur_zero;
        logic out_free;
    } t_status;

    typedef logic [15:0] t_gauss_tab [GAUSS_ENTRIES];

    // exp(-18 u^2) in Q0.16 for u = k / (2 * GAUSS_ENTRIES), by a truncated
    // series raised to the 256th power through eight squarings.
    function automatic t_gauss_tab f_gauss_build();
        t_gauss_tab  tab;
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] y4;
        logic [63:0] r;
        logic [63:0] e;
        one = 64'd1 << 30;
        for (int k = 0; k < GAUSS_ENTRIES; k++) begin
            // The divisor 2 * GAUSS_ENTRIES^2 is a power of two.
            x  = ((64'd9 * 64'(k) * 64'(k)) << 30) >> (1 + 2 * GAUSS_LOG2);
            y  = x >> 8;
            y2 = (y * y) >> 30;
            y3 = (y2 * y) >> 30;
            y4 = (y3 * y) >> 30;
            r  = (one + y2 / 64'd2 + y4 / 64'd24) - (y + y3 / 64'd6);
            for (int i = 0; i < 8; i++) begin
                r = (r * r) >> 30;
            end
            e = (r + (64'd1 << 13)) >> 14;
            tab[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        return tab;
    endfunction

    localparam t_gauss_tab GAUSS_TABLE = f_gauss_build();

endpackage

/* hw/rtl/scg_req_if.sv */
interface scg_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [31:0]        time_req;
    logic [15:0]        node_index;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic [2:0]         window_slot;
    logic [31:0]        window_end;
    logic signed [31:0] window_amplitude;

    modport source (
        output valid, func, time_req, node_index, node_x, node_y,
               window_slot, window_end, window_amplitude,
        input  ready
    );
    modport sink (
        input  valid, func, time_req, node_index, node_x, node_y,
               window_slot, window_end, window_amplitude,
        output ready
    );
endinterface

/* hw/rtl/scg_rsp_if.sv */
interface scg_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        result_node;
    logic signed [31:0] applied_current;
    logic               stimulated;

    modport source (
        output valid, result_node, applied_current, stimulated,
        input  ready
    );
    modport sink (
        input  valid, result_node, applied_current, stimulated,
        output ready
    );
endinterface

/* hw/rtl/scg_cfg_regs.sv */
module scg_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scg_pkg::ADDR_W-1:0]  paddr,
    input  logic [scg_pkg::DATA_W-1:0]  pwdata,
    output logic [scg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output scg_pkg::t_cfg               o_cfg
);

    scg_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pulse_period: 32'd1, default: '0};
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                scg_pkg::REG_MODE:     r_cfg.mode            <= pwdata[2:0];
                scg_pkg::REG_START:    r_cfg.pulse_start     <= pwdata[31:0];
                scg_pkg::REG_DURATION: r_cfg.pulse_duration  <= pwdata[31:0];
                scg_pkg::REG_PERIOD:   r_cfg.pulse_period    <= pwdata[31:0];
                scg_pkg::REG_AMP:      r_cfg.pulse_amplitude <= $signed(pwdata[31:0]);
                scg_pkg::REG_AREA_LO:  r_cfg.area_low        <= pwdata;
                scg_pkg::REG_AREA_HI:  r_cfg.area_high       <= pwdata;
                scg_pkg::REG_WCOUNT:   r_cfg.window_count    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            scg_pkg::REG_MODE:     prdata = {61'd0, r_cfg.mode};
            scg_pkg::REG_START:    prdata = {32'd0, r_cfg.pulse_start};
            scg_pkg::REG_DURATION: prdata = {32'd0, r_cfg.pulse_duration};
            scg_pkg::REG_PERIOD:   prdata = {32'd0, r_cfg.pulse_period};
            scg_pkg::REG_AMP:      prdata = {32'd0, r_cfg.pulse_amplitude};
            scg_pkg::REG_AREA_LO:  prdata = r_cfg.area_low;
            scg_pkg::REG_AREA_HI:  prdata = r_cfg.area_high;
            scg_pkg::REG_WCOUNT:   prdata = {60'd0, r_cfg.window_count};
            default:               prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/scg_dp.sv */
module scg_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scg_pkg::t_cfg      i_cfg,
    input  scg_pkg::t_req      i_req,
    input  scg_pkg::t_cmd      i_cmd,
    output scg_pkg::t_status   o_status,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [15:0]        o_result_node,
    output logic signed [31:0] o_applied_current,
    output logic               o_stimulated
);

    // Captured item
    logic [31:0]        r_t;
    logic [15:0]        r_node;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;

    // Window table
    logic [31:0]        r_win_start [scg_pkg::MAX_WINDOWS];
    logic [31:0]        r_win_end   [scg_pkg::MAX_WINDOWS];
    logic signed [31:0] r_win_amp   [scg_pkg::MAX_WINDOWS];

    // Multiplier and area test
    logic signed [scg_pkg::PROD_W-1:0] r_prod;
    logic signed [scg_pkg::PROD_W-1:0] r_sa;
    logic signed [scg_pkg::PROD_W-1:0] r_sb;
    logic                              r_inside;

    // Divider
    logic [31:0]               r_rem;
    logic [scg_pkg::DVD_W-1:0] r_dvd;
    logic [31:0]               r_quo;
    logic [31:0]               r_dvs;
    logic [31:0]               r_d;

    logic               r_need_gauss;
    logic signed [31:0] r_cur;
    logic               r_hit;

    logic               r_out_valid;
    logic [15:0]        r_out_node;
    logic signed [31:0] r_out_cur;
    logic               r_out_hit;

    logic signed [31:0] w_ax, w_ay, w_ac, w_ad, w_amp;
    logic signed [32:0] w_dx, w_dy, w_cx;
    logic [32:0]        w_ux, w_uy;
    logic [31:0]        w_ur;
    logic [31:0]        w_per;
    logic               w_spatial;
    logic               w_rect_in;
    logic               w_circ_in;

    logic signed [scg_pkg::MUL_W-1:0]  w_ma, w_mb;
    logic signed [scg_pkg::PROD_W-1:0] w_prod;
    logic signed [scg_pkg::PROD_W-1:0] w_round;

    logic [32:0] w_rem_sh;
    logic        w_qbit;

    logic [32:0] w_base;
    logic [33:0] w_end;
    logic [34:0] w_tw, w_cw, w_dist;
    logic        w_in_win;

    logic [scg_pkg::GAUSS_LOG2-1:0] w_k;
    logic [15:0]                    w_g;
    logic                           w_win_hit;
    logic                           w_slot_ok;

    assign w_ax      = $signed(i_cfg.area_low[63:32]);
    assign w_ay      = $signed(i_cfg.area_low[31:0]);
    assign w_ac      = $signed(i_cfg.area_high[63:32]);
    assign w_ad      = $signed(i_cfg.area_high[31:0]);
    assign w_amp     = $signed(i_cfg.pulse_amplitude);
    assign w_spatial = i_cfg.mode[scg_pkg::MODE_SPATIAL];
    assign w_per     = (i_cfg.pulse_period == 32'd0) ? 32'd1 : i_cfg.pulse_period;

    assign w_dx = 33'(r_x) - 33'(w_ax);
    assign w_dy = 33'(r_y) - 33'(w_ay);
    assign w_cx = 33'(w_ac);
    assign w_ux = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_uy = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_ur = w_cx[32] ? 32'(-w_cx) : w_cx[31:0];

    assign w_rect_in = (r_x >= w_ax) && (r_x <= w_ac) && (r_y >= w_ay) && (r_y <= w_ad);
    // r_prod holds radius squared in the area evaluation cycle.
    assign w_circ_in = (r_sa + r_sb) < r_prod;

    always_comb begin
        case (i_cmd.mul_sel)
            scg_pkg::MUL_SQX: begin
                w_ma = $signed({1'b0, w_ux});
                w_mb = $signed({1'b0, w_ux});
            end
            scg_pkg::MUL_SQY: begin
                w_ma = $signed({1'b0, w_uy});
                w_mb = $signed({1'b0, w_uy});
            end
            scg_pkg::MUL_SQR: begin
                w_ma = $signed({2'b0, w_ur});
                w_mb = $signed({2'b0, w_ur});
            end
            scg_pkg::MUL_NP: begin
                w_ma = $signed({2'b0, r_quo});
                w_mb = $signed({2'b0, w_per});
            end
            scg_pkg::MUL_AMP: begin
                w_ma = scg_pkg::MUL_W'(w_amp);
                w_mb = $signed({18'b0, w_g});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    assign w_round = r_prod + scg_pkg::PROD_W'(32768);

    assign w_rem_sh = {r_rem, r_dvd[scg_pkg::DVD_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dvs});

    // r_prod holds n * period in the base cycle; it never exceeds the time.
    assign w_base   = {1'b0, i_cfg.pulse_start} + {1'b0, r_prod[31:0]};
    assign w_end    = {1'b0, w_base} + {2'b0, i_cfg.pulse_duration};
    assign w_in_win = ({1'b0, r_t} >= w_base) && ({2'b0, r_t} <= w_end);
    assign w_tw     = {2'b0, r_t, 1'b0};
    assign w_cw     = {1'b0, w_base, 1'b0} + {3'b0, i_cfg.pulse_duration};
    assign w_dist   = (w_tw >= w_cw) ? (w_tw - w_cw) : (w_cw - w_tw);

    always_comb begin
        if (i_cfg.pulse_duration == 32'd0) begin
            w_k = '0;
        end else if (r_quo >= 32'(scg_pkg::GAUSS_ENTRIES)) begin
            w_k = scg_pkg::GAUSS_LOG2'(scg_pkg::GAUSS_ENTRIES - 1);
        end else begin
            w_k = r_quo[scg_pkg::GAUSS_LOG2-1:0];
        end
    end
    assign w_g = scg_pkg::GAUSS_TABLE[w_k];

    assign w_win_hit = (r_t >= r_win_start[i_cmd.scan_idx])
                    && (r_t <= r_win_end[i_cmd.scan_idx])
                    && (!w_spatial || r_inside);
    assign w_slot_ok = (32'(i_req.window_slot) < scg_pkg::MAX_WINDOWS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_write && w_slot_ok) begin
            r_win_start[scg_pkg::WIN_IDX_W'(i_req.window_slot)] <= i_req.time_req;
            r_win_end[scg_pkg::WIN_IDX_W'(i_req.window_slot)]   <= i_req.window_end;
            r_win_amp[scg_pkg::WIN_IDX_W'(i_req.window_slot)]   <= i_req.window_amplitude;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load_item) begin
            r_t    <= i_req.time_req;
            r_node <= i_req.node_index;
            r_x    <= i_req.node_x;
            r_y    <= i_req.node_y;
        end
        if (i_cmd.save_sa) begin
            r_sa <= r_prod;
        end
        if (i_cmd.save_sb) begin
            r_sb <= r_prod;
        end
        if (i_cmd.area_eval) begin
            r_inside <= i_cfg.mode[scg_pkg::MODE_RECT] ? w_rect_in : w_circ_in;
        end
        if (i_cmd.div_load_p) begin
            r_dvd <= {r_t, scg_pkg::GAUSS_LOG2'(0)};
            r_dvs <= w_per;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_load_g) begin
            r_dvd <= {r_d, scg_pkg::GAUSS_LOG2'(0)};
            r_dvs <= i_cfg.pulse_duration;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_qbit ? 32'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[31:0];
            r_quo <= {r_quo[30:0], w_qbit};
        end
        if (i_cmd.base_calc) begin
            r_d          <= w_dist[31:0];
            r_need_gauss <= w_in_win && w_spatial && r_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_hit <= 1'b0;
            end else if (i_cmd.scan_step && w_win_hit) begin
                r_hit <= 1'b1;
            end else if (i_cmd.base_calc && w_in_win && !w_spatial) begin
                r_hit <= 1'b1;
            end else if (i_cmd.gauss_res) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cur <= '0;
        end else if (i_cmd.scan_step && w_win_hit) begin
            r_cur <= r_win_amp[i_cmd.scan_idx];
        end else if (i_cmd.base_calc && w_in_win && !w_spatial) begin
            r_cur <= w_amp;
        end else if (i_cmd.gauss_res) begin
            r_cur <= w_round[47:16];
        end
        if (i_cmd.out_load) begin
            r_out_node <= r_node;
            r_out_cur  <= r_cur;
            r_out_hit  <= r_hit;
        end
    end

    assign o_status.need_gauss = r_need_gauss;
    assign o_status.dur_zero   = (i_cfg.pulse_duration == 32'd0);
    assign o_status.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid       = r_out_valid;
    assign o_result_node     = r_out_node;
    assign o_applied_current = r_out_cur;
    assign o_stimulated      = r_out_hit;

endmodule

/* hw/rtl/scg_ctrl.sv */
module scg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scg_pkg::t_cfg    i_cfg,
    input  logic             i_req_valid,
    input  logic             i_req_func,
    output logic             o_req_ready,
    input  scg_pkg::t_status i_status,
    output scg_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQR,
        S_AREA,
        S_SCAN,
        S_DIVP,
        S_MULNP,
        S_BASE,
        S_DECIDE,
        S_DIVG,
        S_GMUL,
        S_GRES,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic [scg_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [scg_pkg::CNT_W-1:0] w_scan_lim;

    assign w_scan_lim = (32'(i_cfg.window_count) > scg_pkg::MAX_WINDOWS)
                      ? scg_pkg::CNT_W'(scg_pkg::MAX_WINDOWS)
                      : scg_pkg::CNT_W'(i_cfg.window_count);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.mul_sel = scg_pkg::MUL_SQX;
        o_req_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_func) begin
                        o_cmd.win_write = 1'b1;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_state         = S_SQX;
                    end
                end
            end
            S_SQX: begin
                o_cmd.mul_sel = scg_pkg::MUL_SQX;
                n_state       = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul_sel = scg_pkg::MUL_SQY;
                o_cmd.save_sa = 1'b1;
                n_state       = S_SQR;
            end
            S_SQR: begin
                o_cmd.mul_sel = scg_pkg::MUL_SQR;
                o_cmd.save_sb = 1'b1;
                n_state       = S_AREA;
            end
            S_AREA: begin
                o_cmd.area_eval = 1'b1;
                n_cnt           = '0;
                if (i_cfg.mode[scg_pkg::MODE_MANUAL]) begin
                    n_state = (w_scan_lim == '0) ? S_DONE : S_SCAN;
                end else begin
                    o_cmd.div_load_p = 1'b1;
                    n_state          = S_DIVP;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_idx  = r_cnt[scg_pkg::WIN_IDX_W-1:0];
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == w_scan_lim - 1'b1) begin
                    n_state = S_DONE;
                end
            end
            S_DIVP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == scg_pkg::CNT_W'(scg_pkg::DIVP_STEPS - 1)) begin
                    n_state = S_MULNP;
                end
            end
            S_MULNP: begin
                o_cmd.mul_sel = scg_pkg::MUL_NP;
                n_state       = S_BASE;
            end
            S_BASE: begin
                o_cmd.base_calc = 1'b1;
                n_state         = S_DECIDE;
            end
            S_DECIDE: begin
                n_cnt = '0;
                if (!i_status.need_gauss) begin
                    n_state = S_DONE;
                end else if (i_status.dur_zero) begin
                    n_state = S_GMUL;
                end else begin
                    o_cmd.div_load_g = 1'b1;
                    n_state          = S_DIVG;
                end
            end
            S_DIVG: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == scg_pkg::CNT_W'(scg_pkg::DIVG_STEPS - 1)) begin
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                o_cmd.mul_sel = scg_pkg::MUL_AMP;
                n_state       = S_GRES;
            end
            S_GRES: begin
                o_cmd.gauss_res = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded over an untaken result");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_req_ready)
        else $error("input ready while an item is in work");

    a_idle_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after a result");

    a_eval_starts_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |=> (r_state == S_SQX))
        else $error("evaluation did not start with the area test");
`endif

endmodule

/* hw/rtl/stimulus_current_generator.sv */
// Channel   Direction  Handshake        Payload
// i_req     in         valid / ready    func, time_req, node_index, node_x, node_y,
//                                       window_slot, window_end, window_amplitude
// o_rsp     out        valid / ready    result_node, applied_current, stimulated
// APB       in         psel / penable   paddr, pwdata (write), prdata (read)
//
// A window write beat is absorbed in the cycle it is accepted. An evaluate beat
// runs the area test, then in manual mode scans the configured windows, one per
// cycle; in automatic mode it divides the time by the period and, with the Gaussian
// shaping, the pulse distance by the duration for the table index, on one radix-2 divider.
// Reset is synchronous and active low and restores the register defaults; the
// window table holds no valid data until written. A result waits in an output
// register, so a stalled o_rsp never blocks the next input beat from being taken,
// but the next result cannot finish until the previous one is taken.
module stimulus_current_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    scg_req_if.sink                    i_req,
    scg_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scg_pkg::ADDR_W-1:0] paddr,
    input  logic [scg_pkg::DATA_W-1:0] pwdata,
    output logic [scg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    scg_pkg::t_cfg    w_cfg;
    scg_pkg::t_req    w_req;
    scg_pkg::t_cmd    w_cmd;
    scg_pkg::t_status w_status;

    // Gather the input channel into one payload word for the datapath.
    assign w_req.func             = i_req.func;
    assign w_req.time_req         = i_req.time_req;
    assign w_req.node_index       = i_req.node_index;
    assign w_req.node_x           = i_req.node_x;
    assign w_req.node_y           = i_req.node_y;
    assign w_req.window_slot      = i_req.window_slot;
    assign w_req.window_end       = i_req.window_end;
    assign w_req.window_amplitude = i_req.window_amplitude;

    // Register file behind the APB port.
    scg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller sequences area test, window scan, division and scaling.
    scg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath owns the window table, the shared multiplier and divider,
    // and the output register.
    scg_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_req             (w_req),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_rsp_valid       (o_rsp.valid),
        .i_rsp_ready       (o_rsp.ready),
        .o_result_node     (o_rsp.result_node),
        .o_applied_current (o_rsp.applied_current),
        .o_stimulated      (o_rsp.stimulated)
    );

endmodule

/* test/tb_stimulus_current_generator.sv */
`timescale 1ns / 1ps

module tb_stimulus_current_generator;

    localparam int CYCLE_LIMIT = 1500000;
    // Covers the slowest evaluate beat, the Gaussian-shaped one, with margin.
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [15:0]        node;
        logic signed [31:0] current;
        logic               stim;
    } t_current_rsp;

    typedef enum int {
        ROW_CFG,
        ROW_BEAT
    } t_row_kind;

    // One row of the directed table. A register write or a beat; a beat may
    // carry a typed-in expected current, otherwise the predictor decides.
    typedef struct {
        t_row_kind          kind;
        logic [2:0]         reg_idx;
        logic [63:0]        reg_val;
        scg_pkg::t_req      beat;
        bit                 typed;
        logic signed [31:0] typed_current;
        logic               typed_stim;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [scg_pkg::ADDR_W-1:0] paddr;
    logic [scg_pkg::DATA_W-1:0] pwdata;
    logic [scg_pkg::DATA_W-1:0] prdata;
    logic pready;

    scg_req_if req_ch ();
    scg_rsp_if rsp_ch ();

    stimulus_current_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file and the window table.
    logic [2:0]         cfg_mode;
    logic [31:0]        cfg_start;
    logic [31:0]        cfg_duration;
    logic [31:0]        cfg_period;
    logic signed [31:0] cfg_amp;
    logic [63:0]        cfg_area_lo;
    logic [63:0]        cfg_area_hi;
    logic [3:0]         cfg_wcount;

    logic [31:0]        win_start [scg_pkg::MAX_WINDOWS];
    logic [31:0]        win_end   [scg_pkg::MAX_WINDOWS];
    logic signed [31:0] win_amp   [scg_pkg::MAX_WINDOWS];
    logic [15:0]        gauss_lut [scg_pkg::GAUSS_ENTRIES];

    t_current_rsp pending_currents[$];
    t_row         directed_rows[$];

    int idle_pct;
    int stall_pct;
    int mismatches;
    int cycles;
    int n_evals;
    int n_writes;
    int n_hits;
    int n_cfg_writes;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_currents.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Each table entry is exp(-18 u^2) in Q0.16: a series to the fourth power for
    // exp(-x/256), raised to the 256th power by eight squarings.
    function automatic void build_gauss_lut();
        longint unsigned unity;
        longint unsigned xa;
        longint unsigned ya;
        longint unsigned p2;
        longint unsigned p3;
        longint unsigned p4;
        longint unsigned acc;
        longint unsigned rounded;
        longint unsigned entries;
        unity = 64'd1 << 30;
        entries = scg_pkg::GAUSS_ENTRIES;
        for (int k = 0; k < scg_pkg::GAUSS_ENTRIES; k++) begin
            xa = ((64'd9 * longint'(k) * longint'(k)) << 30) / (2 * entries * entries);
            ya = xa >> 8;
            p2 = (ya * ya) >> 30;
            p3 = (p2 * ya) >> 30;
            p4 = (p3 * ya) >> 30;
            acc = (unity + p2 / 2 + p4 / 24) - (ya + p3 / 6);
            for (int s = 0; s < 8; s++) begin
                acc = (acc * acc) >> 30;
            end
            rounded = (acc + (64'd1 << 13)) >> 14;
            gauss_lut[k] = (rounded > 65535) ? 16'hFFFF : rounded[15:0];
        end
    endfunction

    function automatic bit node_in_area(logic signed [31:0] nx, logic signed [31:0] ny);
        longint sx;
        longint sy;
        longint ax;
        longint ay;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint unsigned sqx;
        longint unsigned sqy;
        longint unsigned sqr;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned ur;
        sx = longint'(nx);
        sy = longint'(ny);
        ax = longint'($signed(cfg_area_lo[63:32]));
        ay = longint'($signed(cfg_area_lo[31:0]));
        cx = longint'($signed(cfg_area_hi[63:32]));
        cy = longint'($signed(cfg_area_hi[31:0]));
        if (cfg_mode[scg_pkg::MODE_RECT]) begin
            return (sx >= ax) && (sx <= cx) && (sy >= ay) && (sy <= cy);
        end
        // Circle: strictly inside the radius; the upper half of area_high
        // is the radius and its sign is ignored.
        dx = sx - ax;
        dy = sy - ay;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        ur = (cx < 0) ? -cx : cx;
        sqx = ux * ux;
        sqy = uy * uy;
        sqr = ur * ur;
        if (sqx >= sqr) begin
            return 1'b0;
        end
        return sqy < (sqr - sqx);
    endfunction

    function automatic t_current_rsp predict_current(scg_pkg::t_req r);
        t_current_rsp res;
        longint unsigned t;
        longint unsigned per;
        longint unsigned dur;
        longint unsigned base;
        longint unsigned tw;
        longint unsigned cw;
        longint unsigned gap;
        longint unsigned k;
        longint          cur;
        bit              hit;
        bit              in_zone;
        int              cnt;
        t = r.time_req;
        cur = 0;
        hit = 1'b0;
        in_zone = node_in_area(r.node_x, r.node_y);
        if (cfg_mode[scg_pkg::MODE_MANUAL]) begin
            // The last matching window wins.
            cnt = (cfg_wcount > scg_pkg::MAX_WINDOWS) ? scg_pkg::MAX_WINDOWS : cfg_wcount;
            for (int i = 0; i < cnt; i++) begin
                if (t >= win_start[i] && t <= win_end[i] &&
                    (!cfg_mode[scg_pkg::MODE_SPATIAL] || in_zone)) begin
                    cur = longint'(win_amp[i]);
                    hit = 1'b1;
                end
            end
        end else begin
            per = (cfg_period == 0) ? 1 : cfg_period;
            dur = cfg_duration;
            base = longint'(cfg_start) + (t / per) * per;
            if (t >= base && t <= base + dur) begin
                if (!cfg_mode[scg_pkg::MODE_SPATIAL]) begin
                    cur = longint'(cfg_amp);
                    hit = 1'b1;
                end else if (in_zone) begin
                    // Gaussian centered in the pulse, sigma = duration / 6.
                    tw = 2 * t;
                    cw = 2 * base + dur;
                    gap = (tw >= cw) ? tw - cw : cw - tw;
                    k = (dur != 0) ? (gap * scg_pkg::GAUSS_ENTRIES) / dur : 0;
                    if (k >= scg_pkg::GAUSS_ENTRIES) begin
                        k = scg_pkg::GAUSS_ENTRIES - 1;
                    end
                    cur = (longint'(cfg_amp) * longint'({48'd0, gauss_lut[k]}) + 32768)
                          >>> 16;
                    hit = 1'b1;
                end
            end
        end
        res.node = r.node_index;
        res.current = cur[31:0];
        res.stim = hit;
        return res;
    endfunction

    // Checks each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_current_rsp want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_currents.size() == 0) begin
                $display("%0t: unexpected result node=%h current=%h stim=%b", $time,
                         rsp_ch.result_node, rsp_ch.applied_current, rsp_ch.stimulated);
                mismatches++;
            end else begin
                want = pending_currents.pop_front();
                if (rsp_ch.result_node !== want.node) begin
                    $display("%0t: result_node expected %h actual %h", $time,
                             want.node, rsp_ch.result_node);
                    mismatches++;
                end
                if (rsp_ch.applied_current !== want.current) begin
                    $display("%0t: applied_current (node %h) expected %h actual %h", $time,
                             want.node, want.current, rsp_ch.applied_current);
                    mismatches++;
                end
                if (rsp_ch.stimulated !== want.stim) begin
                    $display("%0t: stimulated (node %h) expected %b actual %b", $time,
                             want.node, want.stim, rsp_ch.stimulated);
                    mismatches++;
                end
            end
        end
    end

    // The receiver stalls at random; its share of stalled cycles is set per phase.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void shadow_register(logic [2:0] idx, logic [63:0] val);
        case (idx)
            scg_pkg::REG_MODE:     cfg_mode = val[2:0];
            scg_pkg::REG_START:    cfg_start = val[31:0];
            scg_pkg::REG_DURATION: cfg_duration = val[31:0];
            scg_pkg::REG_PERIOD:   cfg_period = val[31:0];
            scg_pkg::REG_AMP:      cfg_amp = val[31:0];
            scg_pkg::REG_AREA_LO:  cfg_area_lo = val;
            scg_pkg::REG_AREA_HI:  cfg_area_hi = val;
            scg_pkg::REG_WCOUNT:   cfg_wcount = val[3:0];
            default: ;
        endcase
    endfunction

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        shadow_register(idx, val);
        n_cfg_writes++;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Registers change only with the block idle: every result in, then the
    // longest evaluate latency on top. Called at a falling edge.
    task automatic settle();
        req_ch.valid = 1'b0;
        while (pending_currents.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Offers one beat after a random number of idle cycles and records what
    // it should produce once accepted. Starts and ends at a falling edge.
    task automatic send_beat(scg_pkg::t_req r, bit typed, logic signed [31:0] tcur,
                             logic tstim);
        t_current_rsp want;
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func = r.func;
        req_ch.time_req = r.time_req;
        req_ch.node_index = r.node_index;
        req_ch.node_x = r.node_x;
        req_ch.node_y = r.node_y;
        req_ch.window_slot = r.window_slot;
        req_ch.window_end = r.window_end;
        req_ch.window_amplitude = r.window_amplitude;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (r.func) begin
            // All eight slots exist, so every slot value is a real write.
            win_start[r.window_slot] = r.time_req;
            win_end[r.window_slot] = r.window_end;
            win_amp[r.window_slot] = r.window_amplitude;
            n_writes++;
        end else begin
            if (typed) begin
                want.node = r.node_index;
                want.current = tcur;
                want.stim = tstim;
            end else begin
                want = predict_current(r);
            end
            if (want.stim) begin
                n_hits++;
            end
            pending_currents = {pending_currents, want};
            n_evals++;
        end
        @(negedge i_clk);
    endtask

    function automatic scg_pkg::t_req make_eval(logic [31:0] t, logic [15:0] node,
                                                logic [31:0] nx, logic [31:0] ny);
        scg_pkg::t_req r;
        r.func = 1'b0;
        r.time_req = t;
        r.node_index = node;
        r.node_x = nx;
        r.node_y = ny;
        r.window_slot = 3'($urandom());
        r.window_end = $urandom();
        r.window_amplitude = $urandom();
        return r;
    endfunction

    function automatic scg_pkg::t_req make_window(logic [2:0] slot, logic [31:0] ws,
                                                  logic [31:0] we, logic [31:0] wa);
        scg_pkg::t_req r;
        r.func = 1'b1;
        r.time_req = ws;
        r.node_index = 16'($urandom());
        r.node_x = $urandom();
        r.node_y = $urandom();
        r.window_slot = slot;
        r.window_end = we;
        r.window_amplitude = wa;
        return r;
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [63:0] val);
        t_row row;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed = 1'b0;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_beat(scg_pkg::t_req r, bit typed, logic [31:0] tcur,
                                     logic tstim);
        t_row row;
        row.kind = ROW_BEAT;
        row.beat = r;
        row.typed = typed;
        row.typed_current = tcur;
        row.typed_stim = tstim;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void build_directed_table();
        // Right after reset: period 1 and duration 0 make every time a
        // single-instant hit with zero amplitude.
        add_beat(make_eval(32'd0, 16'h0000, 32'd0, 32'd0), 1'b1, 32'd0, 1'b1);
        add_cfg(scg_pkg::REG_AMP, 64'h7FFF_FFFF);
        add_beat(make_eval(32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000),
                 1'b1, 32'h7FFF_FFFF, 1'b1);
        // A zero period behaves as a period of one.
        add_cfg(scg_pkg::REG_PERIOD, 64'd0);
        add_beat(make_eval(32'd12345, 16'h0001, 32'h8000_0000, 32'h7FFF_FFFF),
                 1'b1, 32'h7FFF_FFFF, 1'b1);
        // Pulse [100, 150] in every 1000: both ends inclusive.
        add_cfg(scg_pkg::REG_PERIOD, 64'd1000);
        add_cfg(scg_pkg::REG_START, 64'd100);
        add_cfg(scg_pkg::REG_DURATION, 64'd50);
        add_beat(make_eval(32'd99, 16'h0002, 32'd0, 32'd0), 1'b1, 32'd0, 1'b0);
        add_beat(make_eval(32'd150, 16'h0003, 32'd0, 32'd0), 1'b1, 32'h7FFF_FFFF, 1'b1);
        add_beat(make_eval(32'd151, 16'h0004, 32'd0, 32'd0), 1'b1, 32'd0, 1'b0);
        // Spatial circle of radius 1.0 at the origin, negative peak.
        add_cfg(scg_pkg::REG_AMP, 64'h8000_0000);
        add_cfg(scg_pkg::REG_MODE, 64'd2);
        add_cfg(scg_pkg::REG_AREA_LO, 64'd0);
        add_cfg(scg_pkg::REG_AREA_HI, {32'h0001_0000, 32'h0});
        add_beat(make_eval(32'd125, 16'h0005, 32'd0, 32'd0), 1'b0, 32'd0, 1'b0);
        // A node exactly on the radius is outside.
        add_beat(make_eval(32'd130, 16'h0006, 32'h0001_0000, 32'd0), 1'b1, 32'd0, 1'b0);
        add_beat(make_eval(32'd100, 16'h0007, 32'd0, 32'h0000_8000), 1'b0, 32'd0, 1'b0);
        // Rectangle [-1, 1] x [-1, 1]: the corner counts as inside.
        add_cfg(scg_pkg::REG_MODE, 64'd6);
        add_cfg(scg_pkg::REG_AREA_LO, {32'hFFFF_0000, 32'hFFFF_0000});
        add_cfg(scg_pkg::REG_AREA_HI, {32'h0001_0000, 32'h0001_0000});
        add_beat(make_eval(32'd140, 16'h0008, 32'h0001_0000, 32'hFFFF_0000),
                 1'b0, 32'd0, 1'b0);
        // Fill every window slot before any manual scan reads one.
        for (int s = 0; s < scg_pkg::MAX_WINDOWS; s++) begin
            add_beat(make_window(s[2:0], 32'(s * 400), 32'(s * 400 + 300),
                                 (s == 0) ? 32'h8000_0000 :
                                 (s == scg_pkg::MAX_WINDOWS - 1) ? 32'h7FFF_FFFF :
                                 $urandom()),
                     1'b0, 32'd0, 1'b0);
        end
        // A count above the table size scans the whole table.
        add_cfg(scg_pkg::REG_WCOUNT, 64'd15);
        add_cfg(scg_pkg::REG_MODE, 64'd1);
        add_beat(make_eval(32'd2900, 16'h0009, 32'd0, 32'd0), 1'b0, 32'd0, 1'b0);
        add_beat(make_eval(32'd350, 16'h000A, 32'd0, 32'd0), 1'b0, 32'd0, 1'b0);
    endfunction

    // A coordinate near the configured area, sometimes right on its edge.
    function automatic logic [31:0] near_coord(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return lo + hi;
            default: return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
        endcase
    endfunction

    // New register set for a random stretch; now and then an extreme one.
    task automatic randomize_settings();
        logic [31:0] per;
        logic [31:0] st;
        logic [31:0] dur;
        logic [31:0] amp;
        logic [63:0] alo;
        logic [63:0] ahi;
        per = $urandom_range(16, 4096);
        st = $urandom_range(0, per / 2);
        dur = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, per / 2 - 1);
        amp = $urandom();
        alo = {32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000,
               32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000};
        ahi = {32'($urandom_range(0, 32'h0008_0000)) - 32'h0002_0000,
               32'($urandom_range(0, 32'h0008_0000)) - 32'h0002_0000};
        if ($urandom_range(0, 4) == 0) begin
            per = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            st = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            dur = 32'hFFFF_FFFF;
            amp = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            alo = $urandom_range(0, 1) ? 64'h8000_0000_8000_0000 : 64'h7FFF_FFFF_7FFF_FFFF;
            ahi = $urandom_range(0, 1) ? 64'h8000_0000_7FFF_FFFF : {$urandom(), $urandom()};
        end
        settle();
        apb_write(scg_pkg::REG_MODE, 64'($urandom_range(0, 7)));
        apb_write(scg_pkg::REG_START, 64'(st));
        apb_write(scg_pkg::REG_DURATION, 64'(dur));
        apb_write(scg_pkg::REG_PERIOD, 64'(per));
        apb_write(scg_pkg::REG_AMP, 64'(amp));
        apb_write(scg_pkg::REG_AREA_LO, alo);
        apb_write(scg_pkg::REG_AREA_HI, ahi);
        apb_write(scg_pkg::REG_WCOUNT, 64'($urandom_range(0, 15)));
    endtask

    // Mostly well-aimed beats: times around pulses or windows, nodes around
    // the area. About one in five is fully random noise.
    function automatic scg_pkg::t_req random_beat();
        scg_pkg::t_req r;
        logic [31:0] t;
        logic [31:0] ws;
        longint unsigned per;
        bit noise;
        noise = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 12) begin
            ws = noise ? $urandom() : $urandom_range(0, 4000);
            return make_window(3'($urandom()), ws,
                               noise ? $urandom() : ws + $urandom_range(0, 500), $urandom());
        end
        if (noise) begin
            return make_eval($urandom(), 16'($urandom()), $urandom(), $urandom());
        end
        if (cfg_mode[scg_pkg::MODE_MANUAL]) begin
            t = $urandom_range(0, 4500);
        end else begin
            per = (cfg_period == 0) ? 1 : cfg_period;
            t = 32'(longint'(cfg_start) + longint'($urandom_range(0, 20)) * per
                    + $urandom_range(0, cfg_duration + 2 > 600 ? 600 : cfg_duration + 2)) - 1;
        end
        r = make_eval(t, 16'($urandom()),
                      near_coord(cfg_area_lo[63:32], cfg_area_hi[63:32]),
                      near_coord(cfg_area_lo[31:0], cfg_area_hi[31:0]));
        return r;
    endfunction

    initial begin
        t_row row;
        req_ch.valid = 1'b0;
        req_ch.func = 1'b0;
        req_ch.time_req = '0;
        req_ch.node_index = '0;
        req_ch.node_x = '0;
        req_ch.node_y = '0;
        req_ch.window_slot = '0;
        req_ch.window_end = '0;
        req_ch.window_amplitude = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        cycles = 0;
        n_evals = 0;
        n_writes = 0;
        n_hits = 0;
        n_cfg_writes = 0;
        cfg_mode = 3'd0;
        cfg_start = 32'd0;
        cfg_duration = 32'd0;
        cfg_period = 32'd1;
        cfg_amp = 32'sd0;
        cfg_area_lo = 64'd0;
        cfg_area_hi = 64'd0;
        cfg_wcount = 4'd0;
        build_gauss_lut();
        build_directed_table();

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with no idling.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                apb_write(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.beat, row.typed, row.typed_current, row.typed_stim);
            end
        end

        // Random part: four idling phases, each with four register settings.
        // Every settings change holds the sender until all results are back.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            for (int chunk = 0; chunk < 4; chunk++) begin
                randomize_settings();
                for (int n = 0; n < 40; n++) begin
                    send_beat(random_beat(), 1'b0, 32'd0, 1'b0);
                end
            end
        end

        settle();
        $display("Covered %0d evaluate beats (%0d stimulated), %0d window writes,",
                 n_evals, n_hits, n_writes);
        $display("and %0d register writes over four idling phases.", n_cfg_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/scg_pkg.sv
hw/rtl/scg_req_if.sv
hw/rtl/scg_rsp_if.sv
hw/rtl/scg_cfg_regs.sv
hw/rtl/scg_dp.sv
hw/rtl/scg_ctrl.sv
hw/rtl/stimulus_current_generator.sv
test/tb_stimulus_current_generator.sv
